### rtl/dtd_pkg.sv
// Shared types, constants and calendar helper functions for the date-time difference unit.
package dtd_pkg;

  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [22:0] day_cnt_t;
  typedef logic [2:0]  weekday_t;

  typedef struct packed {
    year_t   year_a;
    month_t  month_a;
    day_t    day_a;
    hour_t   hour_a;
    minute_t minute_a;
    second_t second_a;
    year_t   year_b;
    month_t  month_b;
    day_t    day_b;
    hour_t   hour_b;
    minute_t minute_b;
    second_t second_b;
  } dtd_in_t;

  typedef struct packed {
    logic     valid_a;
    logic     valid_b;
    day_cnt_t diff_days;
    hour_t    diff_hours;
    minute_t  diff_minutes;
    second_t  diff_seconds;
    weekday_t weekday_a;
    weekday_t weekday_b;
    logic     time_present;
  } dtd_out_t;

  localparam month_t  MonthJan    = 4'd1;
  localparam month_t  MonthFeb    = 4'd2;
  localparam month_t  MonthDec    = 4'd12;
  localparam hour_t   MaxHour     = 5'd23;
  localparam minute_t MaxMinute   = 6'd59;
  localparam second_t MaxSecond   = 6'd59;
  localparam logic [6:0] SecsPerMin  = 7'd60;
  localparam logic [6:0] MinsPerHour = 7'd60;
  localparam logic [5:0] HoursPerDay = 6'd24;
  localparam day_cnt_t DaysPerYear = 23'd365;

  // floor(q / 25) for q below 4096 is (q * 2622) >> 16.
  localparam logic [11:0] Recip25    = 12'd2622;
  localparam int unsigned Recip25Shr = 16;

  // Century number floor(y / 100), computed as floor(floor(y / 4) / 25).
  function automatic logic [7:0] div100(year_t y);
    logic [23:0] prod;
    prod = {12'd0, y[13:2]} * {12'd0, Recip25};
    return prod[Recip25Shr +: 8];
  endfunction

  function automatic day_t month_len(month_t m);
    day_t n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [8:0] cum_days(month_t m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Since 8 = 1 mod 7, the sum of the octal digits keeps the residue.
  function automatic weekday_t mod7(day_cnt_t v);
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = {4'd0, v[22:21]};
    for (int i = 0; i < 7; i++) begin
      s = s + {3'd0, v[3*i +: 3]};
    end
    t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    u = t[2:0] + {2'd0, t[3]};
    return (u == 3'd7) ? 3'd0 : u;
  endfunction

endpackage

### rtl/dtd_stream_if.sv
// Valid/ready stream interface that carries one payload of type T.
interface dtd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/dtd_date_conv.sv
// Checks one date-time and converts its date to a day count since 0001-01-01.
module dtd_date_conv (
  input  dtd_pkg::year_t    year_i,
  input  dtd_pkg::month_t   month_i,
  input  dtd_pkg::day_t     day_i,
  input  dtd_pkg::hour_t    hour_i,
  input  dtd_pkg::minute_t  minute_i,
  input  dtd_pkg::second_t  second_i,
  output logic              valid_o,
  output dtd_pkg::day_cnt_t day_cnt_o,
  output logic              time_present_o
);
  import dtd_pkg::*;

  logic [7:0]  cent;
  logic [7:0]  prev_cent;
  logic [11:0] cent_x25;
  logic        div4;
  logic        div100_y;
  logic        div400;
  logic        leap;
  year_t       prev_year;
  day_t        mlen;

  assign cent     = div100(year_i);
  assign cent_x25 = 12'({4'd0, cent} * 12'd25);
  assign div4     = (year_i[1:0] == 2'b00);
  assign div100_y = div4 && (year_i[13:2] == cent_x25);
  assign div400   = div100_y && (cent[1:0] == 2'b00);
  assign leap     = div4 && (!div100_y || div400);

  // The century count of the previous year drops by one exactly when this
  // year is a multiple of 100.
  assign prev_year = year_i - 14'd1;
  assign prev_cent = cent - {7'd0, div100_y};

  assign day_cnt_o = 23'(prev_year) * DaysPerYear
                   + 23'(prev_year[13:2])
                   - 23'(prev_cent)
                   + 23'(prev_cent[7:2])
                   + 23'(cum_days(month_i))
                   + 23'(leap && (month_i > MonthFeb))
                   + 23'(day_i)
                   - 23'd1;

  always_comb begin
    mlen = month_len(month_i);
    if (month_i == MonthFeb && leap) begin
      mlen = 5'd29;
    end
  end

  assign valid_o = (year_i != 14'd0) && (month_i >= MonthJan) && (month_i <= MonthDec)
                && (day_i != 5'd0) && (day_i <= mlen) && (hour_i <= MaxHour)
                && (minute_i <= MaxMinute) && (second_i <= MaxSecond);

  assign time_present_o = (hour_i != 5'd0) && (minute_i != 6'd0) && (second_i != 6'd0);

endmodule

### rtl/datetime_difference_unit.sv
// Date-time difference unit: takes a pair of proleptic Gregorian date-times per transaction,
// checks both, and returns the absolute difference as days, hours, minutes and seconds
// together with each date's weekday (0 is Monday) and the time-present flag; when either
// date-time is invalid only the two valid flags can be set. The unit is a three-register
// pipeline (input register, day-count register, result register): it accepts one
// transaction per cycle while input ready is high and passes it through them in that order. The
// result register and the two stages before it absorb output stalls, so input ready drops
// only when all three stages hold a transaction and the output is not taken.
module datetime_difference_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtd_stream_if.sink   in_i,
  dtd_stream_if.source out_o
);
  import dtd_pkg::*;

  typedef struct packed {
    logic     va;
    logic     vb;
    logic     tp;
    day_cnt_t dca;
    day_cnt_t dcb;
    hour_t    ha;
    minute_t  ma;
    second_t  sa;
    hour_t    hb;
    minute_t  mb;
    second_t  sb;
  } mid_t;

  logic     v0_q, v1_q, v2_q;
  logic     adv0, adv1, adv2;
  dtd_in_t  in_q;
  mid_t     mid_d, mid_q;
  dtd_out_t out_d, out_q;

  logic     va, vb, tpa, tpb;
  day_cnt_t dca, dcb;

  // Pipeline flow: a stage moves on when it is empty or the next one moves.
  assign adv2       = !v2_q || out_o.ready;
  assign adv1       = !v1_q || adv2;
  assign adv0       = !v0_q || adv1;
  assign in_i.ready = adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_i.valid;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (adv1 && v0_q) begin
      mid_q <= mid_d;
    end
    if (adv2 && v1_q) begin
      out_q <= out_d;
    end
  end

  dtd_date_conv u_conv_a (
    .year_i         (in_q.year_a),
    .month_i        (in_q.month_a),
    .day_i          (in_q.day_a),
    .hour_i         (in_q.hour_a),
    .minute_i       (in_q.minute_a),
    .second_i       (in_q.second_a),
    .valid_o        (va),
    .day_cnt_o      (dca),
    .time_present_o (tpa)
  );

  dtd_date_conv u_conv_b (
    .year_i         (in_q.year_b),
    .month_i        (in_q.month_b),
    .day_i          (in_q.day_b),
    .hour_i         (in_q.hour_b),
    .minute_i       (in_q.minute_b),
    .second_i       (in_q.second_b),
    .valid_o        (vb),
    .day_cnt_o      (dcb),
    .time_present_o (tpb)
  );

  always_comb begin
    mid_d.va  = va;
    mid_d.vb  = vb;
    mid_d.tp  = tpa || tpb;
    mid_d.dca = dca;
    mid_d.dcb = dcb;
    mid_d.ha  = in_q.hour_a;
    mid_d.ma  = in_q.minute_a;
    mid_d.sa  = in_q.second_a;
    mid_d.hb  = in_q.hour_b;
    mid_d.mb  = in_q.minute_b;
    mid_d.sb  = in_q.second_b;
  end

  // The difference is taken field by field with borrows, larger moment minus smaller.
  // For valid moments the ordering of {days, hour, minute, second} is the time order.
  logic       a_ge;
  day_cnt_t   big_d, sml_d;
  hour_t      big_h, sml_h;
  minute_t    big_m, sml_m;
  second_t    big_s, sml_s;
  logic [6:0] ds, ds_adj, dm, dm_adj;
  logic [5:0] dh, dh_adj;
  logic       bs, bm, bh;

  always_comb begin
    a_ge = {mid_q.dca, mid_q.ha, mid_q.ma, mid_q.sa}
        >= {mid_q.dcb, mid_q.hb, mid_q.mb, mid_q.sb};
    big_d = a_ge ? mid_q.dca : mid_q.dcb;
    sml_d = a_ge ? mid_q.dcb : mid_q.dca;
    big_h = a_ge ? mid_q.ha  : mid_q.hb;
    sml_h = a_ge ? mid_q.hb  : mid_q.ha;
    big_m = a_ge ? mid_q.ma  : mid_q.mb;
    sml_m = a_ge ? mid_q.mb  : mid_q.ma;
    big_s = a_ge ? mid_q.sa  : mid_q.sb;
    sml_s = a_ge ? mid_q.sb  : mid_q.sa;

    ds     = {1'b0, big_s} - {1'b0, sml_s};
    bs     = ds[6];
    ds_adj = ds + (bs ? SecsPerMin : 7'd0);

    dm     = {1'b0, big_m} - {1'b0, sml_m} - {6'd0, bs};
    bm     = dm[6];
    dm_adj = dm + (bm ? MinsPerHour : 7'd0);

    dh     = {1'b0, big_h} - {1'b0, sml_h} - {5'd0, bm};
    bh     = dh[5];
    dh_adj = dh + (bh ? HoursPerDay : 6'd0);

    out_d         = '0;
    out_d.valid_a = mid_q.va;
    out_d.valid_b = mid_q.vb;
    if (mid_q.va && mid_q.vb) begin
      out_d.diff_days    = big_d - sml_d - {22'd0, bh};
      out_d.diff_hours   = dh_adj[4:0];
      out_d.diff_minutes = dm_adj[5:0];
      out_d.diff_seconds = ds_adj[5:0];
      out_d.weekday_a    = mod7(mid_q.dca);
      out_d.weekday_b    = mod7(mid_q.dcb);
      out_d.time_present = mid_q.tp;
    end
  end

  assign out_o.valid = v2_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  // Input back-pressure only comes from a completely full pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v0_q && v1_q && v2_q && !out_o.ready))
    else $error("input stalled while the pipeline has room");

  // An invalid date-time forces every numeric field of the result to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !(out_o.data.valid_a && out_o.data.valid_b)) |->
      (out_o.data.diff_days == '0 && out_o.data.diff_hours == '0
       && out_o.data.diff_minutes == '0 && out_o.data.diff_seconds == '0
       && out_o.data.weekday_a == '0 && out_o.data.weekday_b == '0
       && !out_o.data.time_present))
    else $error("nonzero result fields for an invalid date-time");

  // The borrow chain must leave every remainder field in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.diff_hours <= MaxHour
                     && out_o.data.diff_minutes <= MaxMinute
                     && out_o.data.diff_seconds <= MaxSecond
                     && out_o.data.weekday_a <= 3'd6
                     && out_o.data.weekday_b <= 3'd6))
    else $error("difference or weekday field out of range");

  // A filled middle stage moves into the result register once that register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2) |=> out_o.valid)
    else $error("middle stage transaction lost");
`endif

endmodule

### sim/dtd_diff_checker.sv
// Scoreboard for the date-time difference unit: predicts each result and compares fields.
module dtd_diff_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dtd_pkg::dtd_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dtd_pkg::dtd_out_t out_data_i,
  output int                pending_o,
  output int                mismatch_count_o
);
  import dtd_pkg::*;

  localparam longint unsigned DayLen    = 86400;
  localparam longint unsigned HourLen   = 3600;
  localparam longint unsigned MinuteLen = 60;

  dtd_out_t expected_q[$];
  int       pending = 0;
  int       mismatches = 0;

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Only called with a month in 1..12.
  function automatic int unsigned month_length(int unsigned y, int unsigned mo);
    if (mo == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic bit moment_ok(year_t y, month_t mo, day_t d, hour_t h, minute_t mi,
                                   second_t s);
    if (y == 0 || mo < 1 || mo > 12 || d < 1) begin
      return 1'b0;
    end
    if (d > month_length(y, mo)) begin
      return 1'b0;
    end
    return (h <= 23) && (mi <= 59) && (s <= 59);
  endfunction

  // Days elapsed since 0001-01-01 for a valid date.
  function automatic longint unsigned days_since_epoch(year_t y, month_t mo, day_t d);
    longint unsigned p;
    longint unsigned n;
    p = longint'(y) - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int m = 1; m < mo; m++) begin
      n += month_length(y, m);
    end
    return n + longint'(d) - 1;
  endfunction

  function automatic dtd_out_t predict_difference(dtd_in_t x);
    dtd_out_t        r;
    bit              ok_a;
    bit              ok_b;
    longint unsigned days_a;
    longint unsigned days_b;
    longint unsigned secs_a;
    longint unsigned secs_b;
    longint unsigned span;
    longint unsigned rest;
    r = '0;
    ok_a = moment_ok(x.year_a, x.month_a, x.day_a, x.hour_a, x.minute_a, x.second_a);
    ok_b = moment_ok(x.year_b, x.month_b, x.day_b, x.hour_b, x.minute_b, x.second_b);
    r.valid_a = ok_a;
    r.valid_b = ok_b;
    if (ok_a && ok_b) begin
      days_a = days_since_epoch(x.year_a, x.month_a, x.day_a);
      days_b = days_since_epoch(x.year_b, x.month_b, x.day_b);
      secs_a = days_a * DayLen + 64'(x.hour_a) * HourLen + 64'(x.minute_a) * MinuteLen
             + 64'(x.second_a);
      secs_b = days_b * DayLen + 64'(x.hour_b) * HourLen + 64'(x.minute_b) * MinuteLen
             + 64'(x.second_b);
      span = (secs_a > secs_b) ? secs_a - secs_b : secs_b - secs_a;
      rest = span % DayLen;
      r.diff_days    = day_cnt_t'(span / DayLen);
      r.diff_hours   = hour_t'(rest / HourLen);
      r.diff_minutes = minute_t'((rest % HourLen) / MinuteLen);
      r.diff_seconds = second_t'(rest % MinuteLen);
      r.weekday_a    = weekday_t'(days_a % 7);
      r.weekday_b    = weekday_t'(days_b % 7);
      r.time_present = (x.hour_a != 0 && x.minute_a != 0 && x.second_a != 0) ||
                       (x.hour_b != 0 && x.minute_b != 0 && x.second_b != 0);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [22:0] want,
                               input logic [22:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    dtd_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(predict_difference(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction arrived with no result expected");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("valid_a", 23'(want.valid_a), 23'(out_data_i.valid_a));
          compare_field("valid_b", 23'(want.valid_b), 23'(out_data_i.valid_b));
          compare_field("diff_days", 23'(want.diff_days), 23'(out_data_i.diff_days));
          compare_field("diff_hours", 23'(want.diff_hours), 23'(out_data_i.diff_hours));
          compare_field("diff_minutes", 23'(want.diff_minutes),
                        23'(out_data_i.diff_minutes));
          compare_field("diff_seconds", 23'(want.diff_seconds),
                        23'(out_data_i.diff_seconds));
          compare_field("weekday_a", 23'(want.weekday_a), 23'(out_data_i.weekday_a));
          compare_field("weekday_b", 23'(want.weekday_b), 23'(out_data_i.weekday_b));
          compare_field("time_present", 23'(want.time_present),
                        23'(out_data_i.time_present));
        end
      end
      pending = expected_q.size();
    end
  end

  assign pending_o        = pending;
  assign mismatch_count_o = mismatches;

endmodule

### sim/tb_datetime_difference_unit.sv
// Testbench top for the date-time difference unit: clock, reset, stimulus and the verdict.
module tb_datetime_difference_unit;
  import dtd_pkg::*;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } moment_t;

  localparam int RandomPairs   = 400;
  localparam int HoldOffCycles = 60;
  localparam int TailCycles    = 10;

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   long_stall_requests = 0;
  int   pending_results;
  int   mismatch_count;

  dtd_stream_if #(.T(dtd_in_t))  in_if ();
  dtd_stream_if #(.T(dtd_out_t)) out_if ();

  datetime_difference_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dtd_diff_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .in_data_i        (in_if.data),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_data_i       (out_if.data),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("datetime_difference_unit regression: fail");
    $finish;
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is requested.
  initial begin
    int stalls_done;
    stalls_done = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_done != long_stall_requests) begin
        stalls_done++;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic moment_t stamp(int y, int mo, int d, int h, int mi, int s);
    return '{year_t'(y), month_t'(mo), day_t'(d), hour_t'(h), minute_t'(mi), second_t'(s)};
  endfunction

  // Mostly valid moments; a noisy one has one field (or everything) pushed out of range.
  function automatic moment_t random_moment(bit noisy);
    moment_t     m;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      m.year = year_t'($urandom_range(2100, 1));
    end else if (r < 60) begin
      m.year = year_t'(100 * $urandom_range(163, 1));
    end else begin
      m.year = year_t'($urandom_range(16383, 1));
    end
    m.month = month_t'($urandom_range(12, 1));
    m.day = ($urandom_range(99) < 60) ? day_t'($urandom_range(28, 1))
                                      : day_t'($urandom_range(31, 1));
    if ($urandom_range(9) == 0) begin
      m.month = MonthFeb;
      m.day = day_t'($urandom_range(29, 28));
    end
    m.hour   = hour_t'($urandom_range(23));
    m.minute = minute_t'($urandom_range(59));
    m.second = second_t'($urandom_range(59));
    case ($urandom_range(9))
      0: m.hour = '0;
      1: m.minute = '0;
      2: m.second = '0;
      default: ;
    endcase
    if (noisy) begin
      case ($urandom_range(6))
        0: m.year = '0;
        1: m.month = month_t'($urandom_range(15));
        2: m.day = day_t'($urandom_range(31));
        3: m.hour = hour_t'($urandom_range(31));
        4: m.minute = minute_t'($urandom_range(63));
        5: m.second = second_t'($urandom_range(63));
        default: m = moment_t'({$urandom, $urandom});
      endcase
    end
    return m;
  endfunction

  function automatic dtd_in_t random_pair();
    moment_t     a;
    moment_t     b;
    int unsigned pick;
    a = random_moment($urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 10) begin
      b = a;
    end else if (pick < 35) begin
      // Same day or nearby: exercises small differences and the sub-day split.
      b = a;
      b.hour   = hour_t'($urandom_range(23));
      b.minute = minute_t'($urandom_range(59));
      b.second = second_t'($urandom_range(59));
      if ($urandom_range(1) == 1) begin
        b.day = day_t'($urandom_range(28, 1));
      end
    end else begin
      b = random_moment($urandom_range(99) < 15);
    end
    return {a, b};
  endfunction

  // Offer one transaction and return right after the edge at which it is accepted.
  task automatic send_pair(input moment_t a, input moment_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {a, b};
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending_results == 0);
    @(posedge clk_i);
  endtask

  initial begin
    dtd_in_t item;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    src_idle_pct = 6;
    snk_idle_pct = 79;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(stamp(1, 1, 1, 0, 0, 0), stamp(1, 1, 1, 0, 0, 0));
    send_pair(stamp(1, 1, 1, 0, 0, 0), stamp(16383, 12, 31, 23, 59, 59));
    send_pair(stamp(16383, 12, 31, 23, 59, 59), stamp(1, 1, 1, 0, 0, 0));
    send_pair(stamp(2000, 2, 29, 12, 30, 45), stamp(1900, 2, 28, 1, 1, 1));
    send_pair(stamp(1900, 2, 29, 10, 0, 0), stamp(1900, 3, 1, 10, 0, 0));
    send_pair(stamp(2024, 2, 29, 0, 0, 0), stamp(2023, 2, 29, 0, 0, 0));
    send_pair(stamp(2100, 2, 29, 0, 0, 0), stamp(2400, 2, 29, 6, 7, 8));
    send_pair(stamp(1600, 2, 29, 3, 4, 5), stamp(2000, 3, 1, 0, 0, 0));
    send_pair(stamp(0, 6, 15, 1, 2, 3), stamp(2020, 6, 15, 1, 2, 3));
    send_pair(stamp(2020, 0, 15, 1, 2, 3), stamp(2020, 13, 15, 1, 2, 3));
    send_pair(stamp(2020, 15, 15, 1, 2, 3), stamp(2020, 5, 0, 1, 2, 3));
    send_pair(stamp(2023, 4, 31, 0, 0, 0), stamp(2023, 12, 31, 0, 0, 0));
    send_pair(stamp(2023, 1, 31, 24, 0, 0), stamp(2023, 1, 30, 31, 0, 0));
    send_pair(stamp(2023, 1, 31, 5, 60, 0), stamp(2023, 1, 30, 5, 63, 0));
    send_pair(stamp(2023, 1, 31, 5, 5, 60), stamp(2023, 1, 30, 5, 5, 63));
    send_pair(stamp(16383, 15, 31, 31, 63, 63), stamp(16383, 15, 31, 31, 63, 63));
    send_pair(stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0));
    send_pair(stamp(2020, 6, 15, 1, 1, 1), stamp(2020, 6, 15, 0, 0, 0));
    send_pair(stamp(2020, 6, 15, 5, 0, 7), stamp(2020, 6, 16, 0, 9, 9));
    send_pair(stamp(2023, 1, 1, 0, 0, 1), stamp(2023, 12, 31, 23, 59, 59));
    send_pair(stamp(2000, 3, 1, 0, 0, 0), stamp(2000, 2, 28, 23, 59, 59));
    send_pair(stamp(2001, 1, 1, 0, 0, 0), stamp(2000, 12, 31, 0, 0, 0));
    send_pair(stamp(9999, 9, 9, 9, 9, 9), stamp(8191, 7, 31, 22, 58, 58));

    for (int n = 0; n < RandomPairs; n++) begin
      if (n == 133) begin
        src_idle_pct = 79;
        snk_idle_pct = 6;
      end
      if (n == 266) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // The receiver holds off while transactions keep coming, so the pipeline backs up.
      if (n == 60 || n == 300) begin
        long_stall_requests++;
      end
      if (n == 200) begin
        drain_results();
      end
      item = random_pair();
      send_pair(item[79:40], item[39:0]);
    end

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("datetime_difference_unit regression: pass");
    end else begin
      $display("datetime_difference_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/dtd_pkg.sv
rtl/dtd_stream_if.sv
rtl/dtd_date_conv.sv
rtl/datetime_difference_unit.sv
sim/dtd_diff_checker.sv
sim/tb_datetime_difference_unit.sv
